// File: sv/lpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpt_pkg
// Shared types and constants of the page tracker.
// ----------------------------------------------------------------------------
package lpt_pkg;

	localparam int ORDER_DEPTH_DEF = 64;
	localparam int PIN_DEPTH_DEF   = 16;
	localparam logic [31:0] NO_PAGE = 32'hFFFF_FFFF;

	typedef enum logic [3:0] {
		ACT_INSERT   = 4'd0,
		ACT_REMOVE   = 4'd1,
		ACT_TOUCH    = 4'd2,
		ACT_POP      = 4'd3,
		ACT_CONTAINS = 4'd4,
		ACT_CLEAR    = 4'd5,
		ACT_PIN      = 4'd6,
		ACT_UNPIN    = 4'd7,
		ACT_ISPIN    = 4'd8
	} action_t;

	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_ORDER_FULL = 2'd1;
	localparam logic [1:0] ST_PIN_FULL  = 2'd2;
	localparam logic [1:0] ST_NO_POP    = 2'd3;

	// queued command from front to back
	typedef struct packed {
		logic [3:0]  action;
		logic [31:0] page_id;
	} cmd_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_FIND,
		B_SHIFT,
		B_APPEND,
		B_POPRD,
		B_POPCHK,
		B_PINCHK,
		B_PINSCAN,
		B_DONE
	} bstate_t;

endpackage

// File: sv/lru_page_tracker_with_pinning.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_tracker_with_pinning
// LRU page order with a pinned-page set; one result per action.
// ----------------------------------------------------------------------------
// Items enter a two-entry queue and a back-end sequencer runs them one at a
// time. Every action first scans the pin set, one slot a cycle; inserts,
// removes, touches, lookups, pins and unpins may then walk the order memory
// once, one entry a cycle, searching up to the page and shifting the tail
// down behind it to close the gap. A pop repeats the shift and the pin scan
// for each pinned entry it discards. The order memory needs no clearing pass.
module lru_page_tracker_with_pinning #(
	parameter int ORDER_DEPTH = lpt_pkg::ORDER_DEPTH_DEF,
	parameter int PIN_DEPTH   = lpt_pkg::PIN_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  action,
	input  logic [31:0] page_id,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] popped_page,
	output logic        hit,
	output logic [1:0]  status
);
	import lpt_pkg::*;

	cmd_t cmd;
	logic cmd_valid, cmd_ready;

	lpt_front u_front (
		.clk(clk), .arst_n(arst_n), .valid(in_valid), .ready(in_ready),
		.action(action), .page_id(page_id),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
	);

	lpt_back #(.ORDER_DEPTH(ORDER_DEPTH), .PIN_DEPTH(PIN_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
		.cmd(cmd), .out_valid(out_valid), .out_ready(out_ready),
		.popped_page(popped_page), .hit(hit), .status(status)
	);

endmodule

// File: sv/lpt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpt_front
// Accepts items and queues them for the back end in a two-entry queue.
// ----------------------------------------------------------------------------
module lpt_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          valid,
	output logic          ready,
	input  logic [3:0]    action,
	input  logic [31:0]   page_id,
	output logic          cmd_valid,
	input  logic          cmd_ready,
	output lpt_pkg::cmd_t cmd
);
	import lpt_pkg::*;

	cmd_t       q_q [2];
	logic [1:0] cnt_q;
	logic       rd_q, wr_q;
	logic       push, pop;

	assign ready     = (cnt_q != 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = q_q[rd_q];
	assign push      = valid && ready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_q].action  <= action;
			q_q[wr_q].page_id <= page_id;
		end
	end

endmodule

// File: sv/lpt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpt_back
// Executes queued commands on the order memory and the pin set, one entry
// per cycle for scans and shifts.
// ----------------------------------------------------------------------------
module lpt_back #(
	parameter int ORDER_DEPTH = lpt_pkg::ORDER_DEPTH_DEF,
	parameter int PIN_DEPTH   = lpt_pkg::PIN_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  lpt_pkg::cmd_t cmd,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [31:0]   popped_page,
	output logic          hit,
	output logic [1:0]    status
);
	import lpt_pkg::*;

	localparam int OW = $clog2(ORDER_DEPTH);
	localparam int CW = $clog2(ORDER_DEPTH + 1);
	localparam int PW = (PIN_DEPTH > 1) ? $clog2(PIN_DEPTH) : 1;
	localparam int PC = $clog2(PIN_DEPTH + 1);

	logic [31:0]    mem [ORDER_DEPTH];
	logic [31:0]    pin_page_q [PIN_DEPTH];
	logic [PIN_DEPTH-1:0] pin_valid_q;
	logic [CW-1:0]  count_q;

	bstate_t        st_q, st_d;
	cmd_t           c_q;
	logic [CW-1:0]  idx_q, idx_d;
	logic [31:0]    rdata_q;
	logic           append_q, append_d;
	logic [PC-1:0]  pscan_q, pscan_d;
	logic           pinhit_q, pinhit_d;
	logic [PW-1:0]  pslot_q, pslot_d;
	logic           pfree_q, pfree_d;
	logic           ovalid_q;
	logic [31:0]    pop_q;
	logic           hit_q;
	logic [1:0]     stat_q;

	logic           rd_en;
	logic [OW-1:0]  rd_addr;
	logic           wr_en;
	logic [OW-1:0]  wr_addr;
	logic [31:0]    wr_data;
	logic           cnt_dec, cnt_inc, cnt_clr;
	logic           res_en;
	logic [31:0]    res_pop;
	logic           res_hit;
	logic [1:0]     res_stat;
	logic           pin_set, pin_clr, pin_clrall;
	logic [PW-1:0]  pin_idx;
	logic           pm;

	assign cmd_ready   = (st_q == B_IDLE) && !ovalid_q;
	assign out_valid   = ovalid_q;
	assign popped_page = pop_q;
	assign hit         = hit_q;
	assign status      = stat_q;
	assign pm = pin_valid_q[pscan_q[PW-1:0]] && (pin_page_q[pscan_q[PW-1:0]] == c_q.page_id);

	always_comb begin
		st_d = st_q; idx_d = idx_q; append_d = append_q;
		pscan_d = pscan_q; pinhit_d = pinhit_q; pslot_d = pslot_q; pfree_d = pfree_q;
		rd_en = 1'b0; rd_addr = idx_q[OW-1:0];
		wr_en = 1'b0; wr_addr = idx_q[OW-1:0]; wr_data = c_q.page_id;
		cnt_dec = 1'b0; cnt_inc = 1'b0; cnt_clr = 1'b0;
		res_en = 1'b0; res_pop = NO_PAGE; res_hit = 1'b0; res_stat = ST_DONE;
		pin_set = 1'b0; pin_clr = 1'b0; pin_clrall = 1'b0; pin_idx = pslot_q;
		unique case (st_q)
			B_IDLE: begin
				idx_d = '0; pscan_d = '0; pinhit_d = 1'b0; pfree_d = 1'b0;
				pslot_d = '0;
				if (cmd_valid && cmd_ready) st_d = B_PINCHK;
			end
			// scan the pin set, one slot per cycle
			B_PINCHK: begin
				if (pscan_q == PC'(PIN_DEPTH)) begin
					pscan_d = '0;
					priority case (c_q.action)
						ACT_CLEAR: begin
							cnt_clr = 1'b1; pin_clrall = 1'b1; st_d = B_DONE;
						end
						ACT_ISPIN: begin
							res_hit = pinhit_q; st_d = B_DONE;
						end
						ACT_POP: begin
							if (count_q == '0) begin
								res_stat = ST_NO_POP; st_d = B_DONE;
							end else begin
								rd_en = 1'b1; rd_addr = '0; st_d = B_POPRD;
							end
						end
						ACT_PIN: begin
							if (!pinhit_q && !pfree_q) begin
								res_stat = ST_PIN_FULL; st_d = B_DONE;
							end else begin
								if (!pinhit_q) pin_set = 1'b1;
								rd_en = 1'b1; rd_addr = '0; idx_d = CW'(1); st_d = B_FIND;
							end
						end
						ACT_UNPIN: begin
							if (!pinhit_q) st_d = B_DONE;
							else begin
								pin_clr = 1'b1;
								rd_en = 1'b1; rd_addr = '0; idx_d = CW'(1); st_d = B_FIND;
							end
						end
						ACT_TOUCH: begin
							if (pinhit_q) st_d = B_DONE;
							else begin
								rd_en = 1'b1; rd_addr = '0; idx_d = CW'(1); st_d = B_FIND;
							end
						end
						ACT_INSERT, ACT_REMOVE, ACT_CONTAINS: begin
							rd_en = 1'b1; rd_addr = '0; idx_d = CW'(1); st_d = B_FIND;
						end
						default: st_d = B_DONE;
					endcase
				end else begin
					if (pm) begin
						pinhit_d = 1'b1; pslot_d = pscan_q[PW-1:0];
					end else if (!pin_valid_q[pscan_q[PW-1:0]] && !pfree_q && !pinhit_q) begin
						pfree_d = 1'b1; pslot_d = pscan_q[PW-1:0];
					end
					// keep a match ahead of a free slot
					if (pm && !pinhit_q) pslot_d = pscan_q[PW-1:0];
					else if (pinhit_q) pslot_d = pslot_q;
					pscan_d = pscan_q + PC'(1);
				end
			end
			// linear search; rdata_q holds entry idx_q-1
			B_FIND: begin
				if (idx_q > count_q) begin
					// searched all
					priority case (c_q.action)
						ACT_CONTAINS: begin res_hit = 1'b0; st_d = B_DONE; end
						ACT_INSERT, ACT_UNPIN: begin
							if (count_q >= CW'(ORDER_DEPTH)) begin
								res_stat = ST_ORDER_FULL; st_d = B_DONE;
							end else st_d = B_APPEND;
						end
						default: st_d = B_DONE;
					endcase
				end else if (rdata_q == c_q.page_id) begin
					priority case (c_q.action)
						ACT_CONTAINS: begin res_hit = 1'b1; st_d = B_DONE; end
						default: begin
							append_d = (c_q.action == ACT_INSERT) ||
								(c_q.action == ACT_UNPIN) || (c_q.action == ACT_TOUCH);
							rd_en = 1'b1; rd_addr = idx_q[OW-1:0];
							idx_d = idx_q; st_d = B_SHIFT;
						end
					endcase
					idx_d = idx_q;
				end else begin
					rd_en = 1'b1; rd_addr = idx_q[OW-1:0];
					idx_d = idx_q + CW'(1);
				end
			end
			// close the gap: entry idx_q is read, write it to idx_q-1
			B_SHIFT: begin
				if (idx_q >= count_q) begin
					cnt_dec = 1'b1;
					st_d = append_q ? B_APPEND : B_DONE;
					if (c_q.action == ACT_POP) st_d = B_POPCHK;
				end else begin
					wr_en = 1'b1; wr_addr = OW'(idx_q - CW'(1)); wr_data = rdata_q;
					rd_en = 1'b1; rd_addr = OW'(idx_q + CW'(1));
					idx_d = idx_q + CW'(1);
				end
			end
			B_APPEND: begin
				wr_en = 1'b1; wr_addr = count_q[OW-1:0]; cnt_inc = 1'b1; st_d = B_DONE;
			end
			// head read issued; drop it then check the pin set
			B_POPRD: begin
				append_d = 1'b0; idx_d = CW'(1); pscan_d = '0; pinhit_d = 1'b0;
				rd_en = 1'b1; rd_addr = OW'(1);
				st_d = B_SHIFT;
			end
			B_POPCHK: begin
				// c_q.page_id was loaded with the head in the register block
				if (pscan_q == PC'(PIN_DEPTH)) begin
					if (!pinhit_q) begin
						res_pop = c_q.page_id; res_hit = 1'b1; st_d = B_DONE;
					end else if (count_q == '0) begin
						res_stat = ST_NO_POP; st_d = B_DONE;
					end else begin
						rd_en = 1'b1; rd_addr = '0; st_d = B_POPRD;
					end
				end else begin
					if (pm) pinhit_d = 1'b1;
					pscan_d = pscan_q + PC'(1);
				end
			end
			B_DONE: st_d = B_IDLE;
			default: st_d = B_IDLE;
		endcase
		// result is captured on the last step of every path
		if (st_d == B_DONE && st_q != B_DONE) res_en = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE; count_q <= '0; pin_valid_q <= '0; ovalid_q <= 1'b0;
			idx_q <= '0; pscan_q <= '0; pinhit_q <= 1'b0; pfree_q <= 1'b0;
			append_q <= 1'b0; pslot_q <= '0;
		end else begin
			st_q <= st_d; idx_q <= idx_d; pscan_q <= pscan_d; pinhit_q <= pinhit_d;
			pfree_q <= pfree_d; append_q <= append_d;
			pslot_q <= pslot_d;
			if (cnt_clr) count_q <= '0;
			else if (cnt_dec) count_q <= count_q - CW'(1);
			else if (cnt_inc) count_q <= count_q + CW'(1);
			if (pin_clrall) pin_valid_q <= '0;
			else if (pin_set) pin_valid_q[pin_idx] <= 1'b1;
			else if (pin_clr) pin_valid_q[pin_idx] <= 1'b0;
			if (res_en) ovalid_q <= 1'b1;
			else if (out_ready) ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) c_q <= cmd;
		else if (st_q == B_POPRD) c_q.page_id <= rdata_q;
		if (rd_en) rdata_q <= mem[rd_addr];
		if (wr_en) mem[wr_addr] <= wr_data;
		if (pin_set) pin_page_q[pin_idx] <= c_q.page_id;
		if (res_en) begin
			pop_q <= res_pop; hit_q <= res_hit; stat_q <= res_stat;
		end
	end

endmodule

// File: tb/sv/lru_page_tracker_with_pinning_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_tracker_with_pinning_tb
// Self-checking bench for the LRU page tracker with pinning. Directed rows and
// loops cover corner cases (full stores, pinned pops, undefined actions), then
// about 2000 random actions on a small pool of page ids. Results are checked
// against a behavioural model of the order and pin stores or the fixed rows.
// ----------------------------------------------------------------------------
module lru_page_tracker_with_pinning_tb;
	import lpt_pkg::*;

	localparam int ODEP = ORDER_DEPTH_DEF;
	localparam int PDEP = PIN_DEPTH_DEF;
	localparam int WDOG_LIMIT = 200000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [3:0]  action = 4'd0;
	logic [31:0] page_id = 32'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] popped_page;
	logic        hit;
	logic [1:0]  status;

	typedef struct {
		logic [31:0] page;
		logic        hit;
		logic [1:0]  status;
		bit          fixed;
	} page_result_t;

	typedef struct {
		logic [3:0]  act;
		logic [31:0] id;
		bit          fixed;
		logic [31:0] page;
		logic        hit;
		logic [1:0]  status;
	} row_t;

	// model state
	logic [31:0] lru_list[$];
	logic [31:0] pin_slot[PDEP];
	bit          pin_used[PDEP];

	page_result_t due_results[$];
	int          errors = 0;
	int          idle_in = 0;
	int          stall_out = 0;
	int          hold_cycles = 0;
	int          quiet = 0;
	bit          feeding = 1'b1;

	lru_page_tracker_with_pinning u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .action(action), .page_id(page_id),
		.out_valid(out_valid), .out_ready(out_ready),
		.popped_page(popped_page), .hit(hit), .status(status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int lru_find(logic [31:0] id);
		foreach (lru_list[i])
			if (lru_list[i] == id) return i;
		return -1;
	endfunction

	function automatic int pin_lookup(logic [31:0] id);
		for (int i = 0; i < PDEP; i++)
			if (pin_used[i] && pin_slot[i] == id) return i;
		return -1;
	endfunction

	// returns 1 when the page was dropped for lack of room
	function automatic bit lru_append(logic [31:0] id);
		int p;
		p = lru_find(id);
		if (p >= 0) begin
			lru_list.delete(p);
		end else if (lru_list.size() >= ODEP) begin
			return 1'b1;
		end
		lru_list.push_back(id);
		return 1'b0;
	endfunction

	function automatic page_result_t apply_action(logic [3:0] act, logic [31:0] id);
		page_result_t r;
		int p;
		int s;
		logic [31:0] pg;
		r = '{NO_PAGE, 1'b0, ST_DONE, 1'b0};
		case (act)
			ACT_INSERT: begin
				if (lru_append(id)) r.status = ST_ORDER_FULL;
			end
			ACT_REMOVE: begin
				p = lru_find(id);
				if (p >= 0) lru_list.delete(p);
			end
			ACT_TOUCH: begin
				if (pin_lookup(id) < 0) begin
					p = lru_find(id);
					if (p >= 0) begin
						lru_list.delete(p);
						lru_list.push_back(id);
					end
				end
			end
			ACT_POP: begin
				r.status = ST_NO_POP;
				while (lru_list.size() > 0) begin
					pg = lru_list.pop_front();
					if (pin_lookup(pg) < 0) begin
						r.page = pg;
						r.hit = 1'b1;
						r.status = ST_DONE;
						break;
					end
				end
			end
			ACT_CONTAINS: r.hit = (lru_find(id) >= 0);
			ACT_CLEAR: begin
				lru_list.delete();
				for (int i = 0; i < PDEP; i++) pin_used[i] = 1'b0;
			end
			ACT_PIN: begin
				if (pin_lookup(id) >= 0) begin
					p = lru_find(id);
					if (p >= 0) lru_list.delete(p);
				end else begin
					s = -1;
					for (int i = 0; i < PDEP; i++)
						if (!pin_used[i] && s < 0) s = i;
					if (s < 0) begin
						r.status = ST_PIN_FULL;
					end else begin
						p = lru_find(id);
						if (p >= 0) lru_list.delete(p);
						pin_slot[s] = id;
						pin_used[s] = 1'b1;
					end
				end
			end
			ACT_UNPIN: begin
				s = pin_lookup(id);
				if (s >= 0) begin
					pin_used[s] = 1'b0;
					if (lru_append(id)) r.status = ST_ORDER_FULL;
				end
			end
			ACT_ISPIN: r.hit = (pin_lookup(id) >= 0);
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	// send one action; prediction is taken at the accepting edge
	task automatic send_action(logic [3:0] act, logic [31:0] id, bit fixed = 1'b0,
			logic [31:0] pg = NO_PAGE, logic h = 1'b0, logic [1:0] st = ST_DONE);
		page_result_t r;
		if (idle_in > 0 && $urandom_range(99) < idle_in) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_in) @(posedge clk);
		end
		in_valid <= 1'b1;
		action   <= act;
		page_id  <= id;
		do @(posedge clk); while (!in_ready);
		r = apply_action(act, id);
		if (fixed) begin
			if (r.page != pg || r.hit != h || r.status != st)
				$display("%0t: directed row disagrees with model", $realtime);
			r = '{pg, h, st, 1'b1};
		end
		due_results.push_back(r);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (due_results.size() > 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	// result side
	always @(posedge clk) begin
		page_result_t w;
		if (out_valid && out_ready) begin
			if (due_results.size() == 0) begin
				$display("%0t: unexpected result", $realtime);
				errors++;
			end else begin
				w = due_results.pop_front();
				if (popped_page !== w.page) report_mismatch("popped_page", popped_page, w.page);
				if (hit !== w.hit) report_mismatch("hit", 32'(hit), 32'(w.hit));
				if (status !== w.status) report_mismatch("status", 32'(status), 32'(w.status));
			end
		end
		if (hold_cycles > 0) begin
			hold_cycles--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= (stall_out == 0) || ($urandom_range(99) >= stall_out);
		end
	end

	// watchdog on accepted transfers
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n || !feeding)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic logic [31:0] pick_page();
		case ($urandom_range(9))
			0: return $urandom();
			1: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 12'h0, 4'($urandom_range(15))};
			default: return 32'h100 + $urandom_range(23);
		endcase
	endfunction

	function automatic logic [3:0] pick_action();
		int k;
		k = $urandom_range(99);
		if (k < 30) return ACT_INSERT;
		if (k < 38) return ACT_REMOVE;
		if (k < 48) return ACT_TOUCH;
		if (k < 60) return ACT_POP;
		if (k < 68) return ACT_CONTAINS;
		if (k < 69) return ACT_CLEAR;
		if (k < 80) return ACT_PIN;
		if (k < 89) return ACT_UNPIN;
		if (k < 97) return ACT_ISPIN;
		return 4'($urandom_range(15, 9));
	endfunction

	row_t dir_rows[$];

	initial begin
		int phase_idle[4];
		int phase_stall[4];
		for (int i = 0; i < PDEP; i++) begin
			pin_slot[i] = '0;
			pin_used[i] = 1'b0;
		end
		phase_idle  = '{0, 53, 0, 26};
		phase_stall = '{0, 0, 53, 26};

		dir_rows.push_back('{ACT_POP, 32'h0, 1'b1, NO_PAGE, 1'b0, ST_NO_POP});
		dir_rows.push_back('{ACT_CONTAINS, 32'h0, 1'b1, NO_PAGE, 1'b0, ST_DONE});
		dir_rows.push_back('{ACT_ISPIN, 32'hFFFF_FFFF, 1'b1, NO_PAGE, 1'b0, ST_DONE});
		dir_rows.push_back('{ACT_INSERT, 32'h0, 1'b1, NO_PAGE, 1'b0, ST_DONE});
		dir_rows.push_back('{ACT_INSERT, 32'hFFFF_FFFF, 1'b1, NO_PAGE, 1'b0, ST_DONE});
		dir_rows.push_back('{ACT_INSERT, 32'h5555_AAAA, 1'b0, 32'h0, 1'b0, ST_DONE});
		dir_rows.push_back('{ACT_TOUCH, 32'h0, 1'b0, 32'h0, 1'b0, ST_DONE});
		dir_rows.push_back('{ACT_PIN, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0, ST_DONE});
		dir_rows.push_back('{ACT_PIN, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0, ST_DONE});
		dir_rows.push_back('{ACT_INSERT, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0, ST_DONE});
		dir_rows.push_back('{ACT_TOUCH, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0, ST_DONE});
		dir_rows.push_back('{ACT_POP, 32'h0, 1'b0, 32'h0, 1'b0, ST_DONE});
		dir_rows.push_back('{ACT_CONTAINS, 32'h5555_AAAA, 1'b0, 32'h0, 1'b0, ST_DONE});
		dir_rows.push_back('{ACT_REMOVE, 32'h5555_AAAA, 1'b0, 32'h0, 1'b0, ST_DONE});
		dir_rows.push_back('{ACT_REMOVE, 32'h1234_5678, 1'b0, 32'h0, 1'b0, ST_DONE});
		dir_rows.push_back('{ACT_UNPIN, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0, ST_DONE});
		dir_rows.push_back('{ACT_UNPIN, 32'h1234_5678, 1'b0, 32'h0, 1'b0, ST_DONE});
		dir_rows.push_back('{ACT_ISPIN, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0, ST_DONE});
		dir_rows.push_back('{4'd9, 32'hAAAA_5555, 1'b1, NO_PAGE, 1'b0, ST_DONE});
		dir_rows.push_back('{4'd15, 32'h0, 1'b1, NO_PAGE, 1'b0, ST_DONE});
		dir_rows.push_back('{ACT_CLEAR, 32'h0, 1'b1, NO_PAGE, 1'b0, ST_DONE});
		dir_rows.push_back('{ACT_POP, 32'h0, 1'b1, NO_PAGE, 1'b0, ST_NO_POP});

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_action(dir_rows[i].act, dir_rows[i].id, dir_rows[i].fixed,
				dir_rows[i].page, dir_rows[i].hit, dir_rows[i].status);

		// fill both stores to overflow, then unpin pages and pop from the head
		for (int i = 0; i < ODEP + 2; i++) send_action(ACT_INSERT, 32'h2000 + i);
		for (int i = 0; i < PDEP + 2; i++) send_action(ACT_PIN, 32'h2000 + 2 * i);
		for (int i = 0; i < 4; i++) send_action(ACT_INSERT, 32'h3000 + i);
		send_action(ACT_UNPIN, 32'h2000);
		send_action(ACT_POP, 32'h0);
		send_action(ACT_UNPIN, 32'h2002);
		for (int i = 0; i < 6; i++) send_action(ACT_POP, 32'h0);

		// long receiver hold while items keep coming
		hold_cycles = 3000;
		for (int i = 0; i < 8; i++) send_action(pick_action(), pick_page());

		// pause until all results are back
		drain_results();

		for (int ph = 0; ph < 4; ph++) begin
			idle_in = phase_idle[ph];
			stall_out = phase_stall[ph];
			for (int n = 0; n < 450; n++) begin
				// every so often load a well-formed burst to fill the order store
				if ($urandom_range(499) == 0)
					for (int k = 0; k < ODEP; k++) send_action(ACT_INSERT, pick_page());
				send_action(pick_action(), pick_page());
			end
		end

		idle_in = 0;
		stall_out = 0;
		drain_results();
		feeding = 1'b0;
		if (errors == 0 && due_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
